>>> rtl/bld_pkg.sv
// ----------------------------------------------------------------------------
// bld_pkg
// Shared codes, widths and lane helpers for the byte-lane data RAM.
// ----------------------------------------------------------------------------
package bld_pkg;

    // Word count of the store; a power of two, so the word index is a slice.
    localparam int WORD_DEPTH = 16384;
    localparam int IDX_W      = $clog2(WORD_DEPTH);
    localparam int ADDR_W     = 24;
    localparam int DATA_W     = 32;
    localparam int LANES      = DATA_W / 8;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } size_t;

    // Lane enables for a store; all zero flags an illegal size/offset pair.
    function automatic logic [LANES-1:0] lane_mask(logic [1:0] size, logic [1:0] off);
        logic [LANES-1:0] m;
        m = '0;
        unique case (size)
            SIZE_BYTE: m = 4'b0001 << off;
            SIZE_HALF: m = (off != 2'd3) ? (4'b0011 << off) : 4'b0000;
            SIZE_WORD: m = (off == 2'd0) ? 4'b1111 : 4'b0000;
            default:   m = 4'b0000;
        endcase
        return m;
    endfunction

    function automatic logic [IDX_W-1:0] word_index(logic [ADDR_W-1:0] addr);
        return addr[IDX_W+1:2];
    endfunction

endpackage

>>> rtl/bld_req_if.sv
// ----------------------------------------------------------------------------
// bld_req_if
// Request channel: access op, byte address, store data, size and sign flag.
// ----------------------------------------------------------------------------
interface bld_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [23:0] byte_address;
    logic [31:0] write_data;
    logic [1:0]  access_size;
    logic        sign_extend;

    modport source (output valid, op, byte_address, write_data, access_size,
                    sign_extend, input ready);
    modport sink   (input valid, op, byte_address, write_data, access_size,
                    sign_extend, output ready);
endinterface

>>> rtl/bld_rsp_if.sv
// ----------------------------------------------------------------------------
// bld_rsp_if
// Response channel: aligned load data and store error flag.
// ----------------------------------------------------------------------------
interface bld_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        write_error;

    modport source (output valid, read_data, write_error, input ready);
    modport sink   (input valid, read_data, write_error, output ready);
endinterface

>>> rtl/bld_ram.sv
// ----------------------------------------------------------------------------
// bld_ram
// Single-port-write, single-port-read word RAM with byte enables and a
// registered, read-first output.
// ----------------------------------------------------------------------------
module bld_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [3:0]    be,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            for (int b = 0; b < 4; b++)
            begin
                if (be[b])
                begin
                    mem[waddr][8*b +: 8] <= wdata[8*b +: 8];
                end
            end
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bld_align.sv
// ----------------------------------------------------------------------------
// bld_align
// Load alignment: shift the word down by the lane offset, mask to the size
// and sign-extend narrow data on request.
// ----------------------------------------------------------------------------
module bld_align
    import bld_pkg::*;
(
    input  logic [DATA_W-1:0] word,
    input  logic [1:0]        off,
    input  logic [1:0]        size,
    input  logic              sign,
    output logic [DATA_W-1:0] data
);

    logic [DATA_W-1:0] shifted;

    assign shifted = word >> {off, 3'b000};

    always_comb
    begin
        unique case (size)
            SIZE_BYTE: data = {{24{sign & shifted[7]}}, shifted[7:0]};
            SIZE_HALF: data = {{16{sign & shifted[15]}}, shifted[15:0]};
            default:   data = shifted;
        endcase
    end

endmodule

>>> rtl/byte_lane_data_ram_with_load_align.sv
// ----------------------------------------------------------------------------
// byte_lane_data_ram_with_load_align
// Byte-lane data RAM: byte/halfword/word stores merged by lane enables,
// loads of the held address aligned, masked and sign-extended.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                             | sync
//  req     | in  | op, byte_address, write_data, access_size, sign_ext | valid/ready
//  rsp     | out | read_data, write_error                              | valid/ready
//
//  One item per cycle while the response side does not stall; each result
//  passes the RAM read stage, then alignment into the output register.
//  A store in the same item as its load is forwarded over the RAM output.
//  Reset clears pipeline valids and the held access (address 0, word size).
//  A stalled output holds one result plus one in the RAM stage; req.ready
//  drops only when both are full.
// ----------------------------------------------------------------------------
module byte_lane_data_ram_with_load_align
    import bld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bld_req_if.sink    req,
    bld_rsp_if.source  rsp
);

    logic              accept;
    logic              is_access;
    logic              is_write;
    logic [LANES-1:0]  lanes;
    logic              wr_en;
    logic [DATA_W-1:0] wdata_sh;
    logic [ADDR_W-1:0] rd_addr;
    logic [1:0]        rd_size;
    logic              rd_sign;

    logic [ADDR_W-1:0] held_address_reg;
    logic [1:0]        held_size_reg;
    logic              held_sign_reg;

    logic              s1_valid_reg, s1_valid_next;
    logic [1:0]        s1_off_reg;
    logic [1:0]        s1_size_reg;
    logic              s1_sign_reg;
    logic              s1_err_reg;
    logic [LANES-1:0]  s1_fwd_mask_reg;
    logic [DATA_W-1:0] s1_fwd_data_reg;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_err_reg;

    logic              advance;
    logic [DATA_W-1:0] ram_word;
    logic [DATA_W-1:0] merged;
    logic [DATA_W-1:0] aligned;

    assign accept    = req.valid && req.ready;
    assign is_access = (req.op == OP_READ) || (req.op == OP_WRITE);
    assign is_write  = (req.op == OP_WRITE);
    assign lanes     = lane_mask(req.access_size, req.byte_address[1:0]);
    assign wr_en     = accept && is_write && (lanes != '0);
    assign wdata_sh  = req.write_data << {req.byte_address[1:0], 3'b000};

    // Read the new access, or reread the held one on idle or unused ops.
    assign rd_addr = is_access ? req.byte_address : held_address_reg;
    assign rd_size = is_access ? req.access_size : held_size_reg;
    assign rd_sign = is_access ? req.sign_extend : held_sign_reg;

    assign advance   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || advance;

    bld_ram #(
        .DEPTH (WORD_DEPTH),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .be    (lanes),
        .waddr (word_index(req.byte_address)),
        .wdata (wdata_sh),
        .re    (accept),
        .raddr (word_index(rd_addr)),
        .rdata (ram_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_address_reg <= '0;
            held_size_reg    <= SIZE_WORD;
            held_sign_reg    <= 1'b0;
        end
        else if (accept && is_access)
        begin
            held_address_reg <= req.byte_address;
            held_size_reg    <= req.access_size;
            held_sign_reg    <= req.sign_extend;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A store always targets the word its own load reads, so forward its lanes.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_off_reg      <= rd_addr[1:0];
            s1_size_reg     <= rd_size;
            s1_sign_reg     <= rd_sign;
            s1_err_reg      <= is_write && (lanes == '0);
            s1_fwd_mask_reg <= wr_en ? lanes : '0;
            s1_fwd_data_reg <= wdata_sh;
        end
        if (advance)
        begin
            out_data_reg <= aligned;
            out_err_reg  <= s1_err_reg;
        end
    end

    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            merged[8*b +: 8] = s1_fwd_mask_reg[b] ? s1_fwd_data_reg[8*b +: 8]
                                                  : ram_word[8*b +: 8];
        end
    end

    bld_align u_align (
        .word (merged),
        .off  (s1_off_reg),
        .size (s1_size_reg),
        .sign (s1_sign_reg),
        .data (aligned)
    );

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.write_error = out_err_reg;

endmodule

>>> rtl/bld_checker.sv
// ----------------------------------------------------------------------------
// bld_checker
// Port-level checks on the byte-lane data RAM: reset, result hold, latency, backpressure.
// ----------------------------------------------------------------------------
module bld_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [31:0] rsp_read_data,
    input logic        rsp_write_error
);

    // No result while reset is asserted.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_write_error))
        else $error("stalled result changed");

    // A fresh result follows an accepted item through the RAM stage and the output register.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without matching item");

    // Requests back up only when the output is full and stalled.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request stalled with output free");

endmodule

bind byte_lane_data_ram_with_load_align bld_checker u_bld_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_write_error (rsp.write_error)
);

>>> bench/byte_lane_data_ram_with_load_align_test.sv
// ----------------------------------------------------------------------------
// byte_lane_data_ram_with_load_align_test
// Checks the byte-lane data RAM: every request item is mirrored into a
// shadow store with held access state, and each response item is compared
// field by field with the predicted aligned load data and store error flag.
// Stimulus preloads a pool of words, runs directed lane and alignment cases,
// then random reads, stores and rereads with random stalls on both channels.
// ----------------------------------------------------------------------------
module byte_lane_data_ram_with_load_align_test;
    import bld_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [1:0] SIZE_ILLEGAL = 2'd3;
    localparam int         POOL_WORDS   = 16;
    localparam int         RANDOM_ITEMS = 1400;
    localparam int         CALM_ITEMS   = 200;
    localparam int         STALL_LIMIT  = 1000;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              write_error;
    } load_result_t;

    class lane_ram_scoreboard;
        bit [DATA_W-1:0] word_store [WORD_DEPTH];
        logic [ADDR_W-1:0] held_address;
        logic [1:0]        held_size;
        logic              held_sign;
        load_result_t      expected_loads [$];
        int failures;
        int reads;
        int writes;
        int rejected;
        int rereads;
        int checked;

        function new();
            held_address = '0;
            held_size    = SIZE_WORD;
            held_sign    = 1'b0;
            failures = 0;
            reads    = 0;
            writes   = 0;
            rejected = 0;
            rereads  = 0;
            checked  = 0;
        endfunction

        function int pending();
            return expected_loads.size();
        endfunction

        // Apply one accepted request item and queue the load it returns.
        function void note_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] wdata, logic [1:0] size,
                                   logic sign);
            logic [DATA_W-1:0] lanes;
            logic [DATA_W-1:0] word;
            logic [DATA_W-1:0] data;
            logic [1:0]        off;
            int                idx;
            load_result_t      outcome;

            outcome.write_error = 1'b0;
            if (op == OP_WRITE)
            begin
                off = addr[1:0];
                case (size)
                    SIZE_BYTE: lanes = 32'h0000_00ff << (8 * off);
                    SIZE_HALF: lanes = (off != 2'd3) ? (32'h0000_ffff << (8 * off)) : '0;
                    SIZE_WORD: lanes = (off == 2'd0) ? 32'hffff_ffff : '0;
                    default:   lanes = '0;
                endcase
                if (lanes == '0)
                begin
                    outcome.write_error = 1'b1;
                    rejected++;
                end
                else
                begin
                    idx = int'(addr >> 2) % WORD_DEPTH;
                    word_store[idx] = (word_store[idx] & ~lanes) | ((wdata << (8 * off)) & lanes);
                end
                writes++;
            end
            else if (op == OP_READ)
            begin
                reads++;
            end
            else
            begin
                rereads++;
            end

            if (op == OP_READ || op == OP_WRITE)
            begin
                held_address = addr;
                held_size    = size;
                held_sign    = sign;
            end

            word = word_store[int'(held_address >> 2) % WORD_DEPTH];
            off  = held_address[1:0];
            data = word >> (8 * off);
            if (held_size == SIZE_BYTE)
            begin
                data &= 32'h0000_00ff;
                if (held_sign && data[7])
                    data |= 32'hffff_ff00;
            end
            else if (held_size == SIZE_HALF)
            begin
                data &= 32'h0000_ffff;
                if (held_sign && data[15])
                    data |= 32'hffff_0000;
            end
            outcome.read_data = data;
            expected_loads.push_back(outcome);
        endfunction

        function void check_result(logic [DATA_W-1:0] read_data, logic write_error);
            load_result_t want;

            if (expected_loads.size() == 0)
            begin
                $error("response item with no request pending: read_data %h write_error %b",
                       read_data, write_error);
                failures++;
                return;
            end
            want = expected_loads.pop_front();
            checked++;
            if (read_data !== want.read_data)
            begin
                $error("read_data: expected %h, actual %h", want.read_data, read_data);
                failures++;
            end
            if (write_error !== want.write_error)
            begin
                $error("write_error: expected %b, actual %b", want.write_error, write_error);
                failures++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   calm = 1'b0;
    int   idle_cycles = 0;
    int   hot_words [POOL_WORDS];

    lane_ram_scoreboard board = new();

    bld_req_if req_ch ();
    bld_rsp_if rsp_ch ();

    byte_lane_data_ram_with_load_align DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Address inside a preloaded word, random bits above the index to alias.
    function automatic logic [ADDR_W-1:0] pool_address(int slot, logic [1:0] off);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'($urandom());
        a[IDX_W+1:2] = IDX_W'(hot_words[slot]);
        a[1:0] = off;
        return a;
    endfunction

    task automatic send_access(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] wdata, input logic [1:0] size,
                               input logic sign);
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.byte_address <= addr;
        req_ch.write_data   <= wdata;
        req_ch.access_size  <= size;
        req_ch.sign_extend  <= sign;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic hold_off(input int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_loads();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // Accept side: mirror request items, check response items, watch for hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                board.note_request(req_ch.op, req_ch.byte_address, req_ch.write_data,
                                   req_ch.access_size, req_ch.sign_extend);
            if (rsp_ch.valid && rsp_ch.ready)
                board.check_result(rsp_ch.read_data, rsp_ch.write_error);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Response stalls in random bursts, none once the run goes calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [1:0]        op;
        logic [1:0]        size;
        logic [1:0]        off;
        logic [DATA_W-1:0] wdata;
        int                pick;

        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.op           <= OP_IDLE;
        req_ch.byte_address <= '0;
        req_ch.write_data   <= '0;
        req_ch.access_size  <= SIZE_WORD;
        req_ch.sign_extend  <= 1'b0;

        hot_words[0] = 0;
        hot_words[1] = WORD_DEPTH - 1;
        for (int i = 2; i < POOL_WORDS; i++)
            hot_words[i] = $urandom_range(1, WORD_DEPTH - 2);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every pool word first, so no load ever sees an unwritten entry.
        for (int i = 0; i < POOL_WORDS; i++)
            send_access(OP_WRITE, pool_address(i, 2'd0), $urandom(), SIZE_WORD, 1'b0);

        // Lane extraction and sign extension on a known word, at an aliased address.
        send_access(OP_WRITE, 24'hff0000, 32'h80ff7f01, SIZE_WORD, 1'b0);
        for (int o = 0; o < LANES; o++)
            send_access(OP_READ, 24'hff0000 | 24'(o), '0, SIZE_BYTE, 1'b1);
        send_access(OP_READ, 24'h000003, '1, SIZE_BYTE, 1'b0);
        for (int o = 0; o < 3; o++)
            send_access(OP_READ, 24'h000000 | 24'(o), '0, SIZE_HALF, 1'b1);
        send_access(OP_READ, 24'h000003, '0, SIZE_HALF, 1'b0);
        send_access(OP_READ, 24'h000002, '0, SIZE_WORD, 1'b1);
        send_access(OP_READ, 24'h000001, '0, SIZE_ILLEGAL, 1'b1);
        send_access(OP_IDLE, 24'hffffff, '1, SIZE_BYTE, 1'b0);
        send_access(OP_UNUSED, 24'h000000, '0, SIZE_HALF, 1'b1);

        // Narrow stores into the top word, then rejected combinations.
        send_access(OP_WRITE, 24'hffffff, '1, SIZE_BYTE, 1'b1);
        send_access(OP_WRITE, 24'hfffffd, '0, SIZE_HALF, 1'b0);
        send_access(OP_WRITE, 24'hfffffe, 32'h1234_9abc, SIZE_HALF, 1'b1);
        send_access(OP_WRITE, 24'h00fffc, 32'hffff_8001, SIZE_HALF, 1'b1);
        send_access(OP_WRITE, 24'hffffff, 32'h5555_aaaa, SIZE_HALF, 1'b1);
        send_access(OP_WRITE, 24'hfffffd, '1, SIZE_WORD, 1'b0);
        send_access(OP_WRITE, 24'hfffffc, '1, SIZE_ILLEGAL, 1'b0);
        send_access(OP_WRITE, 24'hfffffc, 32'h0000_0080, SIZE_BYTE, 1'b1);
        send_access(OP_READ, 24'hfffffc, '0, SIZE_WORD, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            if (n == RANDOM_ITEMS / 2)
                drain_loads();
            else if (!calm && $urandom_range(0, 5) == 0)
                hold_off($urandom_range(1, 9));

            pick = $urandom_range(0, 19);
            if (pick < 8)
                op = OP_READ;
            else if (pick < 16)
                op = OP_WRITE;
            else if (pick < 19)
                op = OP_IDLE;
            else
                op = OP_UNUSED;

            pick = $urandom_range(0, 19);
            if (pick < 6)
                size = SIZE_BYTE;
            else if (pick < 12)
                size = SIZE_HALF;
            else if (pick < 19)
                size = SIZE_WORD;
            else
                size = SIZE_ILLEGAL;

            // Keep most word stores aligned so they land rather than get rejected.
            off = 2'($urandom_range(0, 3));
            if (size == SIZE_WORD && $urandom_range(0, 9) < 7)
                off = 2'd0;

            pick = $urandom_range(0, 15);
            if (pick == 0)
                wdata = '0;
            else if (pick == 1)
                wdata = '1;
            else
                wdata = $urandom();

            send_access(op, pool_address($urandom_range(0, POOL_WORDS - 1), off), wdata,
                        size, 1'($urandom_range(0, 1)));
        end

        drain_loads();
        repeat (4) @(posedge clk);

        $display("Covered %0d reads, %0d stores (%0d rejected) and %0d rereads",
                 board.reads, board.writes, board.rejected, board.rereads);
        $display("over %0d pool words; %0d response items checked",
                 POOL_WORDS, board.checked);
        if (board.failures == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> byte_lane_data_ram_with_load_align.f
rtl/bld_pkg.sv
rtl/bld_req_if.sv
rtl/bld_rsp_if.sv
rtl/bld_ram.sv
rtl/bld_align.sv
rtl/byte_lane_data_ram_with_load_align.sv
rtl/bld_checker.sv
bench/byte_lane_data_ram_with_load_align_test.sv
